/* hw/rtl/kvt_pkg.sv */
// Shared types and codes for the linear key/value table.
package kvt_pkg;

	localparam logic [2:0] OP_ACCESS = 3'd0;
	localparam logic [2:0] OP_WRITE  = 3'd1;
	localparam logic [2:0] OP_READ   = 3'd2;
	localparam logic [2:0] OP_ERASE  = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;

	typedef struct packed {
		logic [31:0] key;
		logic [63:0] value;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT
	} state_t;

endpackage

/* hw/rtl/kvt_mem.sv */
// Entry memory: one write port, one read port with registered read data.
module kvt_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  kvt_pkg::entry_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output kvt_pkg::entry_t rdata
);

	kvt_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/linear_key_value_table_core.sv */
// Top level of the linear key/value table: request sequencer and entry memory.
//
// A request (operation, key, write_value) is taken at a rising edge where
// start is high and busy is low. Busy stays high while the request works.
// Its single result (value, found, status, entry_count) is shown for exactly
// one cycle with done high; the receiver cannot stall, so nothing holds it.
// Entries sit in one memory in insertion order. A lookup reads them one per
// cycle from the oldest, pipelined through the registered memory read, and
// compares the returned key. On an erase hit, every later entry then moves
// down one place, one per cycle through the same read and write ports.
// Clear and unused codes finish without a search. The worst case is an erase
// of the oldest entry of a full table.
// A new request may start in the cycle that done is shown.
// Reset empties the table (count zero) and needs no clearing pass: only
// entries below the count are ever read.
module linear_key_value_table_core #(
	parameter int CAPACITY = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [2:0]                    operation,
	input  logic signed [31:0]            key,
	input  logic [63:0]                   write_value,
	output logic                          done,
	output logic [63:0]                   value,
	output logic                          found,
	output logic [1:0]                    status,
	output logic [$clog2(CAPACITY+1)-1:0] entry_count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP = CW'(CAPACITY);

	kvt_pkg::state_t state_q, state_d;

	logic [2:0]      op_q;
	logic [31:0]     key_q;
	logic [63:0]     wval_q;
	logic [CW-1:0]   ptr_q, ptr_d;
	logic [AW-1:0]   idx_q, idx_d;
	logic            rd_vld_q, rd_vld_d;
	logic [CW-1:0]   count_q, count_d;
	logic            done_q, done_d;
	logic [63:0]     val_q, val_d;
	logic            found_q, found_d;
	logic [1:0]      status_q, status_d;

	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	kvt_pkg::entry_t mem_wdata;
	logic            mem_re;
	logic [AW-1:0]   mem_raddr;
	kvt_pkg::entry_t mem_rdata;

	logic accept;
	logic hit;
	logic more;
	logic drained;

	assign busy    = (state_q != kvt_pkg::ST_IDLE);
	assign accept  = start && !busy;
	assign hit     = rd_vld_q && (mem_rdata.key == key_q);
	assign more    = (ptr_q < count_q);
	assign drained = !more && !rd_vld_q;

	kvt_mem #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kvt_pkg::ST_IDLE: begin
				if (accept) begin
					case (operation) inside
						kvt_pkg::OP_ACCESS, kvt_pkg::OP_WRITE,
						kvt_pkg::OP_READ, kvt_pkg::OP_ERASE: state_d = kvt_pkg::ST_SEARCH;
						default: state_d = kvt_pkg::ST_IDLE;
					endcase
				end
			end
			kvt_pkg::ST_SEARCH: begin
				if (hit) begin
					state_d = (op_q == kvt_pkg::OP_ERASE) ? kvt_pkg::ST_SHIFT : kvt_pkg::ST_IDLE;
				end else if (drained) begin
					state_d = kvt_pkg::ST_IDLE;
				end
			end
			kvt_pkg::ST_SHIFT: begin
				if (drained) begin
					state_d = kvt_pkg::ST_IDLE;
				end
			end
			default: state_d = kvt_pkg::ST_IDLE;
		endcase
	end

	// datapath and memory control
	always_comb begin
		ptr_d     = ptr_q;
		idx_d     = idx_q;
		rd_vld_d  = 1'b0;
		count_d   = count_q;
		done_d    = 1'b0;
		val_d     = val_q;
		found_d   = found_q;
		status_d  = status_q;
		mem_re    = 1'b0;
		mem_raddr = ptr_q[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = mem_rdata;
		unique case (state_q)
			kvt_pkg::ST_IDLE: begin
				if (accept) begin
					ptr_d    = '0;
					val_d    = '0;
					found_d  = 1'b0;
					status_d = kvt_pkg::STATUS_OK;
					case (operation) inside
						kvt_pkg::OP_ACCESS, kvt_pkg::OP_WRITE,
						kvt_pkg::OP_READ, kvt_pkg::OP_ERASE: ;
						kvt_pkg::OP_CLEAR: begin
							count_d = '0;
							done_d  = 1'b1;
						end
						default: done_d = 1'b1;
					endcase
				end
			end
			kvt_pkg::ST_SEARCH: begin
				if (hit) begin
					found_d = 1'b1;
					val_d   = mem_rdata.value;
					case (op_q)
						kvt_pkg::OP_WRITE: begin
							mem_we    = 1'b1;
							mem_wdata = '{key: key_q, value: wval_q};
							val_d     = wval_q;
							done_d    = 1'b1;
						end
						kvt_pkg::OP_ERASE: begin
							// close the gap: start reading from the entry after the hit
							ptr_d = CW'(idx_q) + CW'(1);
						end
						default: done_d = 1'b1;
					endcase
				end else if (more) begin
					mem_re   = 1'b1;
					rd_vld_d = 1'b1;
					idx_d    = ptr_q[AW-1:0];
					ptr_d    = ptr_q + CW'(1);
				end else if (!rd_vld_q) begin
					done_d = 1'b1;
					case (op_q)
						kvt_pkg::OP_ACCESS, kvt_pkg::OP_WRITE: begin
							if (count_q == CAP) begin
								status_d = kvt_pkg::STATUS_FULL;
							end else begin
								// append at the tail
								mem_we    = 1'b1;
								mem_waddr = count_q[AW-1:0];
								mem_wdata = '{key: key_q,
									value: (op_q == kvt_pkg::OP_WRITE) ? wval_q : 64'd0};
								val_d     = mem_wdata.value;
								count_d   = count_q + CW'(1);
							end
						end
						kvt_pkg::OP_ERASE: status_d = kvt_pkg::STATUS_NOT_FOUND;
						default: ;
					endcase
				end
			end
			kvt_pkg::ST_SHIFT: begin
				if (rd_vld_q) begin
					mem_we    = 1'b1;
					mem_waddr = idx_q - AW'(1);
				end
				if (more) begin
					mem_re   = 1'b1;
					rd_vld_d = 1'b1;
					idx_d    = ptr_q[AW-1:0];
					ptr_d    = ptr_q + CW'(1);
				end
				if (drained) begin
					count_d = count_q - CW'(1);
					done_d  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= kvt_pkg::ST_IDLE;
			rd_vld_q <= 1'b0;
			count_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= rd_vld_d;
			count_q  <= count_d;
			done_q   <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= operation;
			key_q  <= key;
			wval_q <= write_value;
		end
		ptr_q    <= ptr_d;
		idx_q    <= idx_d;
		val_q    <= val_d;
		found_q  <= found_d;
		status_q <= status_d;
	end

	assign done        = done_q;
	assign value       = val_q;
	assign found       = found_q;
	assign status      = status_q;
	assign entry_count = count_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP)
		else $error("entry count above capacity");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == kvt_pkg::ST_IDLE))
		else $error("result shown while a request is still working");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == kvt_pkg::STATUS_FULL) |-> (count_q == CAP))
		else $error("full status with room left");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done_q))
		else $error("accepted request neither working nor finished");
`endif

endmodule

/* test/linear_key_value_table_core_tb.sv */
// Self-checking testbench for the linear key/value table core.
module linear_key_value_table_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP          = 64;
	localparam int CW           = $clog2(CAP + 1);
	localparam int POOL         = 96;
	localparam int RANDOM_ITEMS = 2000;
	localparam int DRAIN_CYCLES = 2 * CAP + 8;

	localparam logic [2:0]  OP_SPARE5 = 3'd5;
	localparam logic [31:0] KEY_MIN   = 32'h8000_0000;
	localparam logic [31:0] KEY_MAX   = 32'h7fff_ffff;
	localparam logic [31:0] KEY_NEG1  = 32'hffff_ffff;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] key;
		logic [63:0] wval;
		bit          drain_first;
	} request_t;

	typedef struct packed {
		logic [63:0]   value;
		logic          found;
		logic [1:0]    status;
		logic [CW-1:0] count;
	} lookup_result_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic [2:0]    operation = '0;
	logic [31:0]   key = '0;
	logic [63:0]   write_value = '0;
	logic          busy;
	logic          done;
	logic [63:0]   value;
	logic          found;
	logic [1:0]    status;
	logic [CW-1:0] entry_count;

	request_t       request_q[$];
	lookup_result_t expected_q[$];

	// predictor state
	kvt_pkg::entry_t table_mem[CAP];
	int              table_count = 0;

	request_t cur_req;
	bit       have_cur = 1'b0;
	bit       took_word = 1'b0;
	int       words_sent = 0;
	int       words_taken = 0;
	int       results_seen = 0;
	int       mismatches = 0;
	int       hits = 0;
	int       refusals = 0;
	int       erase_misses = 0;
	int       peak_count = 0;
	int       drains = 0;
	logic [31:0] key_pool[POOL];

	linear_key_value_table_core #(.CAPACITY(CAP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.key(key),
		.write_value(write_value),
		.done(done),
		.value(value),
		.found(found),
		.status(status),
		.entry_count(entry_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic lookup_result_t apply_request(input logic [2:0] op,
			input logic [31:0] k, input logic [63:0] wv);
		lookup_result_t r;
		int slot;
		int i;
		bit hit;
		r = '0;
		slot = table_count;
		for (i = table_count - 1; i >= 0; i--)
			if (table_mem[i].key == k) slot = i;
		hit = slot < table_count;
		case (op)
			kvt_pkg::OP_ACCESS, kvt_pkg::OP_WRITE: begin
				r.found = hit;
				if (!hit && table_count >= CAP) begin
					r.status = kvt_pkg::STATUS_FULL;
					refusals++;
				end else begin
					if (!hit) begin
						table_mem[slot].key = k;
						table_mem[slot].value = '0;
						table_count++;
					end
					if (op == kvt_pkg::OP_WRITE)
						table_mem[slot].value = wv;
					r.value = table_mem[slot].value;
				end
			end
			kvt_pkg::OP_READ: begin
				r.found = hit;
				if (hit)
					r.value = table_mem[slot].value;
			end
			kvt_pkg::OP_ERASE: begin
				r.found = hit;
				if (hit) begin
					r.value = table_mem[slot].value;
					for (i = slot; i + 1 < table_count; i++)
						table_mem[i] = table_mem[i + 1];
					table_count--;
				end else begin
					r.status = kvt_pkg::STATUS_NOT_FOUND;
					erase_misses++;
				end
			end
			kvt_pkg::OP_CLEAR: table_count = 0;
			default: ;
		endcase
		if (hit)
			hits++;
		if (table_count > peak_count)
			peak_count = table_count;
		r.count = table_count[CW-1:0];
		return r;
	endfunction

	// Driver: present one word at a time, hold it until taken.
	always @(negedge clk) begin
		bit go;
		go = 1'b0;
		if (arst_n) begin
			if (took_word)
				have_cur = 1'b0;
			if (!have_cur && request_q.size() > 0 &&
					!(request_q[0].drain_first && expected_q.size() > 0)) begin
				cur_req = request_q.pop_front();
				have_cur = 1'b1;
				words_sent++;
				if (cur_req.drain_first)
					drains++;
			end
			// no idling through one long stretch of the run
			go = have_cur && ((words_sent >= 700 && words_sent < 1000) ||
				$urandom_range(0, 99) >= 33);
		end
		start <= go;
		if (go) begin
			operation <= cur_req.op;
			key <= cur_req.key;
			write_value <= cur_req.wval;
		end
	end

	// Monitor: check results, then predict any word taken at this edge.
	always @(posedge clk or negedge arst_n) begin
		lookup_result_t want;
		if (!arst_n) begin
			took_word <= 1'b0;
		end else begin
			if (done) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: value %h found %0b status %0d count %0d",
							value, found, status, entry_count);
				end else begin
					want = expected_q.pop_front();
					if (value !== want.value || found !== want.found ||
							status !== want.status || entry_count !== want.count) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result %0d: expected value %h found %0b status %0d count %0d",
								results_seen, want.value, want.found, want.status, want.count);
							$display("  got value %h found %0b status %0d count %0d",
								value, found, status, entry_count);
						end
					end
				end
			end
			took_word <= start && !busy;
			if (start && !busy) begin
				words_taken++;
				expected_q.push_back(apply_request(operation, key, write_value));
			end
		end
	end

	task automatic add_request(input logic [2:0] op, input logic [31:0] k,
			input logic [63:0] wv, input bit drain);
		request_t r;
		r.op = op;
		r.key = k;
		r.wval = wv;
		r.drain_first = drain;
		request_q.push_back(r);
	endtask

	function automatic logic [63:0] rand_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [2:0] rand_op();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25) return kvt_pkg::OP_ACCESS;
		if (pick < 50) return kvt_pkg::OP_WRITE;
		if (pick < 72) return kvt_pkg::OP_READ;
		if (pick < 94) return kvt_pkg::OP_ERASE;
		if (pick < 97) return kvt_pkg::OP_CLEAR;
		return OP_SPARE5 + 3'($urandom_range(0, 2));
	endfunction

	initial begin
		int n;
		int base;
		int i;
		int j;
		bit dup;
		logic [31:0] k;
		logic [2:0] op;

		// distinct key pool with the extremes up front, larger than the table
		key_pool[0] = KEY_MIN;
		key_pool[1] = KEY_MAX;
		key_pool[2] = '0;
		key_pool[3] = KEY_NEG1;
		for (i = 4; i < POOL; i++) begin
			do begin
				k = $urandom;
				dup = 1'b0;
				for (j = 0; j < i; j++)
					if (key_pool[j] == k) dup = 1'b1;
			end while (dup);
			key_pool[i] = k;
		end

		// directed part
		add_request(kvt_pkg::OP_CLEAR, $urandom, rand_value(), 1'b0);
		add_request(kvt_pkg::OP_READ, KEY_MIN, '1, 1'b0);
		add_request(kvt_pkg::OP_ERASE, KEY_MAX, '1, 1'b0);
		add_request(kvt_pkg::OP_ACCESS, '0, '1, 1'b0);
		add_request(kvt_pkg::OP_WRITE, KEY_MIN, '1, 1'b0);
		add_request(kvt_pkg::OP_WRITE, KEY_MAX, '0, 1'b0);
		add_request(kvt_pkg::OP_ACCESS, KEY_MIN, '0, 1'b0);
		add_request(kvt_pkg::OP_READ, KEY_MAX, '1, 1'b0);
		add_request(kvt_pkg::OP_WRITE, KEY_MIN, 64'h0123_4567_89ab_cdef, 1'b0);
		add_request(kvt_pkg::OP_READ, KEY_NEG1, '0, 1'b0);
		add_request(kvt_pkg::OP_ACCESS, KEY_NEG1, '1, 1'b0);
		add_request(kvt_pkg::OP_ERASE, KEY_MIN, '0, 1'b0);
		add_request(kvt_pkg::OP_READ, KEY_NEG1, '0, 1'b0);
		add_request(kvt_pkg::OP_READ, KEY_MIN, '0, 1'b0);
		for (op = OP_SPARE5; op != kvt_pkg::OP_ACCESS; op++)
			add_request(op, KEY_MAX, '1, 1'b0);
		add_request(kvt_pkg::OP_ERASE, '0, '0, 1'b0);
		add_request(kvt_pkg::OP_ERASE, KEY_NEG1, '0, 1'b0);
		add_request(kvt_pkg::OP_ERASE, KEY_MAX, '0, 1'b0);
		add_request(kvt_pkg::OP_ERASE, KEY_MAX, '1, 1'b0);
		add_request(kvt_pkg::OP_WRITE, 32'd1, 64'h8000_0000_0000_0000, 1'b0);
		add_request(kvt_pkg::OP_CLEAR, '1, '1, 1'b0);
		add_request(kvt_pkg::OP_READ, 32'd1, '0, 1'b0);
		add_request(kvt_pkg::OP_WRITE, KEY_MAX, 64'h7fff_ffff_ffff_ffff, 1'b1);
		n = request_q.size();

		// random part, in segments
		while (request_q.size() < n + RANDOM_ITEMS) begin
			dup = ($urandom_range(0, 7) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					// sweep the pool in order: fills the table and runs into full
					base = $urandom_range(0, POOL - 1);
					for (j = 0; j < $urandom_range(40, 80); j++) begin
						i = $urandom_range(0, 9);
						op = (i < 6) ? kvt_pkg::OP_WRITE :
							(i < 9) ? kvt_pkg::OP_ACCESS : kvt_pkg::OP_READ;
						add_request(op, key_pool[(base + j) % POOL], rand_value(),
							dup && j == 0);
					end
				end
				3, 4, 5, 6: begin
					for (j = 0; j < $urandom_range(20, 100); j++) begin
						k = ($urandom_range(0, 9) == 0) ? $urandom :
							key_pool[$urandom_range(0, POOL - 1)];
						add_request(rand_op(), k, rand_value(), dup && j == 0);
					end
				end
				7: begin
					for (j = 0; j < $urandom_range(10, 60); j++)
						add_request(kvt_pkg::OP_ERASE, key_pool[$urandom_range(0, POOL - 1)],
							rand_value(), dup && j == 0);
				end
				8: begin
					for (j = 0; j < $urandom_range(5, 30); j++)
						add_request(3'($urandom), $urandom, {$urandom, $urandom},
							dup && j == 0);
				end
				default: add_request(kvt_pkg::OP_CLEAR, $urandom, rand_value(), dup);
			endcase
		end

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (request_q.size() > 0 || have_cur || expected_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d words taken, %0d results checked, %0d mismatches", words_taken,
			results_seen, mismatches);
		$display("%0d key hits, %0d inserts refused when full, %0d erase misses,",
			hits, refusals, erase_misses);
		$display("peak %0d of %0d entries, %0d drain pauses", peak_count, CAP, drains);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("linear_key_value_table_core regression: pass");
		else
			$display("linear_key_value_table_core regression: fail");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout waiting for the table to finish");
		$display("linear_key_value_table_core regression: fail");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/kvt_pkg.sv
hw/rtl/kvt_mem.sv
hw/rtl/linear_key_value_table_core.sv
test/linear_key_value_table_core_tb.sv
